FILE: src/lci_pkg.sv
// shared types, constants and saturation helpers for the line circle intersection core
`default_nettype none
package lci_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int EW            = 128;
	localparam int RW            = 64;
	localparam int REMW          = 68;
	localparam int QB            = 33;
	localparam int SQ_CELLS      = RW;

	localparam logic [1:0] PC_NONE = 2'd0;
	localparam logic [1:0] PC_TWO  = 2'd2;

	typedef struct packed {
		logic [31:0] slope;
		logic [31:0] intercept;
		logic [30:0] radius;
	} lci_in_t;

	typedef struct packed {
		logic [31:0] first_x;
		logic [31:0] first_y;
		logic [31:0] second_x;
		logic [31:0] second_y;
		logic [1:0]  point_count;
	} lci_out_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic        pneg;
		logic [63:0] pm;
		logic [63:0] aq;
		logic        cneg;
		logic [63:0] cmag;
		logic        dneg;
	} sq_side_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic        dneg;
		logic        qz;
		logic        neg1;
		logic        neg2;
		logic        ovf1;
		logic        ovf2;
	} dv_side_t;

	function automatic logic [31:0] sat_mag(input logic neg, input logic ovf,
			input logic [QB-1:0] m);
		logic [31:0] r;
		if (neg) begin
			if (ovf || m > QB'(33'h080000000)) r = 32'h80000000;
			else r = 32'd0 - m[31:0];
		end else begin
			if (ovf || m > QB'(33'h07FFFFFFF)) r = 32'h7FFFFFFF;
			else r = m[31:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] line_y(input logic signed [63:0] prod,
			input logic [31:0] b, input int frac);
		logic [63:0]        mag;
		logic [63:0]        t;
		logic signed [65:0] s;
		logic signed [65:0] sum;
		logic [31:0]        r;
		mag = prod[63] ? 64'd0 - prod : prod;
		t   = mag >> frac;
		s   = prod[63] ? -$signed({2'b00, t}) : $signed({2'b00, t});
		sum = s + 66'($signed(b));
		if (sum > 66'sh07FFFFFFF) r = 32'h7FFFFFFF;
		else if (sum < -66'sh080000000) r = 32'h80000000;
		else r = sum[31:0];
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: src/lci_stream_if.sv
// valid/ready stream interface with a typed payload
`default_nettype none
interface lci_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/lci_sqrt_cell.sv
// one digit cell of the pipelined integer square root
`default_nettype none
module lci_sqrt_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      vld_i,
	input  wire logic [lci_pkg::EW-1:0]    rad_i,
	input  wire logic [lci_pkg::REMW-1:0]  rem_i,
	input  wire logic [lci_pkg::RW-1:0]    root_i,
	input  wire lci_pkg::sq_side_t         side_i,
	output logic                           vld_o,
	output logic [lci_pkg::EW-1:0]         rad_o,
	output logic [lci_pkg::REMW-1:0]       rem_o,
	output logic [lci_pkg::RW-1:0]         root_o,
	output lci_pkg::sq_side_t              side_o
);
	import lci_pkg::*;

	logic [REMW-1:0] rem_sh;
	logic [REMW-1:0] trial;
	logic            ge;

	always_comb begin
		rem_sh = {rem_i[REMW-3:0], rad_i[EW-1:EW-2]};
		trial  = {{(REMW-RW-2){1'b0}}, root_i, 2'b01};
		ge     = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_o  <= {rad_i[EW-3:0], 2'b00};
			rem_o  <= ge ? rem_sh - trial : rem_sh;
			root_o <= {root_i[RW-2:0], ge};
			side_o <= side_i;
		end
	end
endmodule
`default_nettype wire

FILE: src/lci_div_cell.sv
// one quotient bit cell for both pipelined dividers
`default_nettype none
module lci_div_cell (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          vld_i,
	input  wire logic [1:0][lci_pkg::QB-1:0]   nb_i,
	input  wire logic [1:0][63:0]              rem_i,
	input  wire logic [1:0][63:0]              den_i,
	input  wire logic [1:0][lci_pkg::QB-1:0]   quo_i,
	input  wire lci_pkg::dv_side_t             side_i,
	output logic                               vld_o,
	output logic [1:0][lci_pkg::QB-1:0]        nb_o,
	output logic [1:0][63:0]                   rem_o,
	output logic [1:0][63:0]                   den_o,
	output logic [1:0][lci_pkg::QB-1:0]        quo_o,
	output lci_pkg::dv_side_t                  side_o
);
	import lci_pkg::*;

	logic [1:0][64:0] rem_sh;
	logic [1:0][64:0] diff;
	logic [1:0]       ge;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			rem_sh[i] = {rem_i[i], nb_i[i][QB-1]};
			diff[i]   = rem_sh[i] - {1'b0, den_i[i]};
			ge[i]     = rem_sh[i] >= {1'b0, den_i[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 2; i++) begin
				nb_o[i]  <= {nb_i[i][QB-2:0], 1'b0};
				rem_o[i] <= ge[i] ? diff[i][63:0] : rem_sh[i][63:0];
				den_o[i] <= den_i[i];
				quo_o[i] <= {quo_i[i][QB-2:0], ge[i]};
			end
			side_o <= side_i;
		end
	end
endmodule
`default_nettype wire

FILE: src/line_circle_intersection_core.sv
// line / circle intersection core: front multipliers, root and divider cell chains, output stage
//
// channel  dir  payload
// lines    in   slope, intercept, radius
// hits     out  first_x, first_y, second_x, second_y, point_count
//
// one line per cycle unless hits stalls; 3 front stages (squares, partial products, discriminant),
// 64 root cells (one root bit each), 2 setup stages, 33 divider cells (one quotient bit each),
// 3 output stages
// the whole pipeline advances together; it holds only while a result waits on hits
// reset clears the valid bits of every stage, no clearing pass
`default_nettype none
module line_circle_intersection_core #(
	parameter int FRAC_BITS = lci_pkg::FRAC_BITS_DEF
) (
	input wire logic     clk,
	input wire logic     arst_n,
	lci_stream_if.sink   lines,
	lci_stream_if.source hits
);
	import lci_pkg::*;

	localparam logic [63:0] AQ_ONE = 64'd1 << (2 * FRAC_BITS);

	logic vld_s6, vld_s7, vld_s8;
	logic en;
	assign en          = !vld_s8 || hits.ready;
	assign lines.ready = en;

	lci_in_t in_c;
	logic [31:0] ma_c, mb_c;
	logic        pneg_c;
	assign in_c   = lines.data;
	assign ma_c   = in_c.slope[31] ? 32'd0 - in_c.slope : in_c.slope;
	assign mb_c   = in_c.intercept[31] ? 32'd0 - in_c.intercept : in_c.intercept;
	assign pneg_c = (in_c.slope[31] != in_c.intercept[31]) && ma_c != 32'd0 && mb_c != 32'd0;

	// stage 1: squares and products
	logic        vld_s1, pneg_s1;
	logic [31:0] a_s1, b_s1;
	logic [63:0] aq_s1, pm_s1, bb_s1, rr_s1;

	// stage 2: partial products of A*r*r
	logic        vld_s2, pneg_s2, cneg_s2;
	logic [31:0] a_s2, b_s2;
	logic [63:0] aq_s2, pm_s2, cmag_s2;
	logic [63:0] pp00_s2, pp01_s2, pp10_s2, pp11_s2;
	logic [EW-1:0] rhs_s2;

	// stage 3: discriminant
	logic          vld_s3;
	logic [EW-1:0] e_s3;
	sq_side_t      side_s3;
	logic [EW-1:0] lhs_c;

	assign lhs_c = {pp11_s2, 64'd0} + {32'd0, pp01_s2, 32'd0} + {32'd0, pp10_s2, 32'd0}
		+ {64'd0, pp00_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= lines.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= in_c.slope;
			b_s1    <= in_c.intercept;
			pneg_s1 <= pneg_c;
			aq_s1   <= 64'(ma_c) * 64'(ma_c) + AQ_ONE;
			pm_s1   <= 64'(ma_c) * 64'(mb_c);
			bb_s1   <= 64'(mb_c) * 64'(mb_c);
			rr_s1   <= 64'(in_c.radius) * 64'(in_c.radius);

			a_s2    <= a_s1;
			b_s2    <= b_s1;
			pneg_s2 <= pneg_s1;
			aq_s2   <= aq_s1;
			pm_s2   <= pm_s1;
			pp00_s2 <= 64'(aq_s1[31:0]) * 64'(rr_s1[31:0]);
			pp01_s2 <= 64'(aq_s1[31:0]) * 64'(rr_s1[63:32]);
			pp10_s2 <= 64'(aq_s1[63:32]) * 64'(rr_s1[31:0]);
			pp11_s2 <= 64'(aq_s1[63:32]) * 64'(rr_s1[63:32]);
			rhs_s2  <= {64'd0, bb_s1} << (2 * FRAC_BITS);
			cneg_s2 <= bb_s1 < rr_s1;
			cmag_s2 <= (bb_s1 < rr_s1) ? rr_s1 - bb_s1 : bb_s1 - rr_s1;

			e_s3         <= lhs_c - rhs_s2;
			side_s3.a    <= a_s2;
			side_s3.b    <= b_s2;
			side_s3.pneg <= pneg_s2;
			side_s3.pm   <= pm_s2;
			side_s3.aq   <= aq_s2;
			side_s3.cneg <= cneg_s2;
			side_s3.cmag <= cmag_s2;
			side_s3.dneg <= lhs_c < rhs_s2;
		end
	end

	// square root chain
	logic     [SQ_CELLS:0]           sq_vld;
	logic     [SQ_CELLS:0][EW-1:0]   sq_rad;
	logic     [SQ_CELLS:0][REMW-1:0] sq_rem;
	logic     [SQ_CELLS:0][RW-1:0]   sq_root;
	sq_side_t [SQ_CELLS:0]           sq_side;

	assign sq_vld[0]  = vld_s3;
	assign sq_rad[0]  = e_s3;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_side[0] = side_s3;

	for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sq
		lci_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (sq_vld[k]),
			.rad_i  (sq_rad[k]),
			.rem_i  (sq_rem[k]),
			.root_i (sq_root[k]),
			.side_i (sq_side[k]),
			.vld_o  (sq_vld[k+1]),
			.rad_o  (sq_rad[k+1]),
			.rem_o  (sq_rem[k+1]),
			.root_o (sq_root[k+1]),
			.side_o (sq_side[k+1])
		);
	end

	// stage 4: |q|
	logic        vld_s4;
	logic [63:0] qm_s4;
	sq_side_t    side_s4;

	// stage 5: divider setup
	logic                  vld_s5;
	logic [1:0][QB-1:0]    nb_s5;
	logic [1:0][63:0]      rem_s5, den_s5;
	dv_side_t              side_s5;
	logic [EW-1:0]         n1_c, n2_c, h1_c, h2_c;
	logic [63:0]           d2_c;
	logic                  qz_c;

	always_comb begin
		qz_c = qm_s4 == 64'd0;
		d2_c = qz_c ? 64'd1 : qm_s4;
		n1_c = {64'd0, qm_s4} << FRAC_BITS;
		n2_c = {64'd0, side_s4.cmag} << FRAC_BITS;
		h1_c = n1_c >> QB;
		h2_c = n2_c >> QB;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s4 <= sq_vld[SQ_CELLS];
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qm_s4   <= sq_side[SQ_CELLS].pm + sq_root[SQ_CELLS];
			side_s4 <= sq_side[SQ_CELLS];

			nb_s5[0]     <= n1_c[QB-1:0];
			nb_s5[1]     <= n2_c[QB-1:0];
			rem_s5[0]    <= h1_c[63:0];
			rem_s5[1]    <= h2_c[63:0];
			den_s5[0]    <= side_s4.aq;
			den_s5[1]    <= d2_c;
			side_s5.a    <= side_s4.a;
			side_s5.b    <= side_s4.b;
			side_s5.dneg <= side_s4.dneg;
			side_s5.qz   <= qz_c;
			side_s5.neg1 <= !side_s4.pneg && !qz_c;
			side_s5.neg2 <= (side_s4.cneg != !side_s4.pneg) && side_s4.cmag != 64'd0;
			side_s5.ovf1 <= h1_c >= {64'd0, side_s4.aq};
			side_s5.ovf2 <= h2_c >= {64'd0, d2_c};
		end
	end

	// divider chain
	logic     [QB:0]               dv_vld;
	logic     [QB:0][1:0][QB-1:0]  dv_nb, dv_quo;
	logic     [QB:0][1:0][63:0]    dv_rem, dv_den;
	dv_side_t [QB:0]               dv_side;

	assign dv_vld[0]  = vld_s5;
	assign dv_nb[0]   = nb_s5;
	assign dv_quo[0]  = '0;
	assign dv_rem[0]  = rem_s5;
	assign dv_den[0]  = den_s5;
	assign dv_side[0] = side_s5;

	for (genvar k = 0; k < QB; k++) begin : g_dv
		lci_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (dv_vld[k]),
			.nb_i   (dv_nb[k]),
			.rem_i  (dv_rem[k]),
			.den_i  (dv_den[k]),
			.quo_i  (dv_quo[k]),
			.side_i (dv_side[k]),
			.vld_o  (dv_vld[k+1]),
			.nb_o   (dv_nb[k+1]),
			.rem_o  (dv_rem[k+1]),
			.den_o  (dv_den[k+1]),
			.quo_o  (dv_quo[k+1]),
			.side_o (dv_side[k+1])
		);
	end

	// stages 6 to 8: saturate x, multiply, y and output register
	logic [31:0] x1_s6, x2_s6, x1_s7, x2_s7;
	logic [31:0] a_s6, b_s6, b_s7;
	logic        dneg_s6, dneg_s7;
	logic signed [63:0] p1_s7, p2_s7;
	lci_out_t    out_s8;
	dv_side_t    dv_last;

	assign dv_last = dv_side[QB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s6 <= dv_vld[QB];
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s6   <= sat_mag(dv_last.neg1, dv_last.ovf1, dv_quo[QB][0]);
			x2_s6   <= dv_last.qz ? 32'd0 : sat_mag(dv_last.neg2, dv_last.ovf2, dv_quo[QB][1]);
			a_s6    <= dv_last.a;
			b_s6    <= dv_last.b;
			dneg_s6 <= dv_last.dneg;

			p1_s7   <= $signed(a_s6) * $signed(x1_s6);
			p2_s7   <= $signed(a_s6) * $signed(x2_s6);
			x1_s7   <= x1_s6;
			x2_s7   <= x2_s6;
			b_s7    <= b_s6;
			dneg_s7 <= dneg_s6;

			if (dneg_s7) begin
				out_s8 <= '{32'd0, 32'd0, 32'd0, 32'd0, PC_NONE};
			end else begin
				out_s8.first_x     <= x1_s7;
				out_s8.first_y     <= line_y(p1_s7, b_s7, FRAC_BITS);
				out_s8.second_x    <= x2_s7;
				out_s8.second_y    <= line_y(p2_s7, b_s7, FRAC_BITS);
				out_s8.point_count <= PC_TWO;
			end
		end
	end

	assign hits.valid = vld_s8;
	assign hits.data  = out_s8;

	a_count_code: assert property (@(posedge clk) disable iff (!arst_n)
		hits.valid |-> (out_s8.point_count == PC_NONE || out_s8.point_count == PC_TWO))
		else $error("bad point count");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(hits.valid && out_s8.point_count == PC_NONE) |->
		(out_s8.first_x == 32'd0 && out_s8.first_y == 32'd0 &&
		 out_s8.second_x == 32'd0 && out_s8.second_y == 32'd0))
		else $error("coordinates not cleared without intersection");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(hits.valid && !hits.ready) |-> !lines.ready)
		else $error("input taken while pipeline stalled");

	a_qz_x2: assert property (@(posedge clk) disable iff (!arst_n)
		(en && dv_vld[QB] && dv_last.qz) |=> x2_s6 == 32'd0)
		else $error("second x not zero for zero q");
endmodule
`default_nettype wire

FILE: verif/tb_line_circle_intersection_core.sv
// testbench for the line circle intersection core: directed table plus random lines, checked by a predictor
`default_nettype none
module tb_line_circle_intersection_core;
	import lci_pkg::*;

	localparam int FB = 16;
	localparam int LATENCY = 105;
	localparam int N_RANDOM = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lci_stream_if #(.T(lci_in_t))  lines ();
	lci_stream_if #(.T(lci_out_t)) hits ();

	line_circle_intersection_core #(.FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n), .lines(lines.sink), .hits(hits.source)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	lci_out_t hit_queue[$];
	int mismatches = 0;
	bit calm = 1'b0;
	bit hold_send = 1'b0;

	function automatic logic [31:0] sat_signed(input logic signed [127:0] v);
		if (v > 128'sh7FFFFFFF) return 32'h7FFFFFFF;
		if (v < -128'sh80000000) return 32'h80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [127:0] div0(input logic signed [127:0] n,
			input logic signed [127:0] d);
		logic [127:0] mn, md, q;
		mn = n < 0 ? -n : n;
		md = d < 0 ? -d : d;
		q = mn / md;
		return ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
	endfunction

	function automatic logic [127:0] isqrt(input logic [127:0] v);
		logic [127:0] lo, hi, mid;
		lo = 0;
		hi = 128'h1_0000_0000_0000_0000;
		while (hi - lo > 1) begin
			mid = (lo + hi) >> 1;
			if (mid * mid <= v) lo = mid;
			else hi = mid;
		end
		return lo;
	endfunction

	function automatic logic [31:0] hit_y(input logic signed [127:0] a,
			input logic [31:0] x, input logic signed [127:0] b);
		logic signed [127:0] p;
		p = a * $signed({{96{x[31]}}, x});
		return sat_signed(div0(p, 128'sd1 <<< FB) + b);
	endfunction

	function automatic lci_out_t predict_hits(input lci_in_t ln);
		logic signed [127:0] a, b, r, aq, p, c, e, s, q;
		lci_out_t o;
		a = $signed({{96{ln.slope[31]}}, ln.slope});
		b = $signed({{96{ln.intercept[31]}}, ln.intercept});
		r = $signed({97'd0, ln.radius});
		aq = a * a + (128'sd1 <<< (2 * FB));
		p = a * b;
		c = b * b - r * r;
		e = aq * r * r - ((b * b) <<< (2 * FB));
		o = '0;
		if (e < 0) return o;
		s = $signed(isqrt(e));
		q = (p >= 0) ? -(p + s) : -(p - s);
		o.point_count = PC_TWO;
		o.first_x = sat_signed(div0(q <<< FB, aq));
		o.second_x = (q == 0) ? 32'd0 : sat_signed(div0(c <<< FB, q));
		o.first_y = hit_y(a, o.first_x, b);
		o.second_y = hit_y(a, o.second_x, b);
		return o;
	endfunction

	// valid stays high after a transaction and drops only while idling
	task automatic send_line(input lci_in_t ln, input bit has_exp, input lci_out_t exp_hit);
		while ((!calm && $urandom_range(99) < 18) || hold_send) begin
			lines.valid <= 1'b0;
			@(posedge clk);
		end
		hit_queue.push_back(has_exp ? exp_hit : predict_hits(ln));
		lines.valid <= 1'b1;
		lines.data <= ln;
		@(posedge clk);
		while (!lines.ready) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) hits.ready <= calm ? 1'b1 : ($urandom_range(99) >= 18);
	end

	always @(posedge clk) begin
		lci_out_t e;
		if (arst_n && hits.valid && hits.ready) begin
			if (hit_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected transaction %h", hits.data);
			end else begin
				e = hit_queue.pop_front();
				if (e.first_x !== hits.data.first_x || e.first_y !== hits.data.first_y ||
						e.second_x !== hits.data.second_x ||
						e.second_y !== hits.data.second_y ||
						e.point_count !== hits.data.point_count) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch: expected %h actual %h",
						e, hits.data);
				end
			end
		end
	end

	typedef struct {
		lci_in_t ln;
		bit has_exp;
		lci_out_t exp_hit;
	} stim_row_t;

	stim_row_t stim_table[] = '{
		'{'{32'h0, 32'h0, 31'h0}, 1'b1, '{32'h0, 32'h0, 32'h0, 32'h0, PC_TWO}},
		'{'{32'h0, 32'h0, 31'h00010000}, 1'b0, '0},
		'{'{32'h0, 32'h00020000, 31'h00010000}, 1'b1, '0},
		'{'{32'h0, 32'h00010000, 31'h00010000}, 1'b0, '0},
		'{'{32'h00010000, 32'h0, 31'h00010000}, 1'b0, '0},
		'{'{32'hFFFF0000, 32'h00008000, 31'h00020000}, 1'b0, '0},
		'{'{32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF}, 1'b0, '0},
		'{'{32'h80000000, 32'h80000000, 31'h7FFFFFFF}, 1'b0, '0},
		'{'{32'h7FFFFFFF, 32'h80000000, 31'h7FFFFFFF}, 1'b0, '0},
		'{'{32'h80000000, 32'h7FFFFFFF, 31'h7FFFFFFF}, 1'b0, '0},
		'{'{32'h0, 32'h7FFFFFFF, 31'h0}, 1'b1, '0},
		'{'{32'h0, 32'h0, 31'h7FFFFFFF}, 1'b0, '0},
		'{'{32'h00000001, 32'h00000001, 31'h00000001}, 1'b0, '0},
		'{'{32'h00100000, 32'hFFF00000, 31'h00300000}, 1'b0, '0},
		'{'{32'hFFFFFFFF, 32'h00000100, 31'h00000100}, 1'b0, '0},
		'{'{32'h00000000, 32'hFFFF0000, 31'h00010000}, 1'b0, '0}
	};

	initial begin
		lci_in_t ln;
		lines.valid = 1'b0;
		lines.data = '0;
		hits.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (stim_table[i]) send_line(stim_table[i].ln, stim_table[i].has_exp,
			stim_table[i].exp_hit);
		lines.valid <= 1'b0;
		hold_send = 1'b1;
		while (hit_queue.size() != 0) @(posedge clk);
		hold_send = 1'b0;
		for (int n = 0; n < N_RANDOM; n++) begin
			calm = (n >= 150 && n < 230);
			ln.slope = $urandom;
			ln.intercept = $urandom;
			ln.radius = 31'($urandom);
			case ($urandom_range(3))
				0: begin
					ln.slope = $signed(ln.slope) >>> $urandom_range(24);
					ln.intercept = $signed(ln.intercept) >>> $urandom_range(24);
				end
				1: ln.radius = ln.radius >> $urandom_range(20);
				2: ln.slope = $signed(ln.slope) >>> 16;
				default: ;
			endcase
			send_line(ln, 1'b0, '0);
		end
		lines.valid <= 1'b0;
		calm = 1'b1;
		while (hit_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (mismatches == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

	initial begin
		#4000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire
